// File: rtl/life_automaton_torus_top_macros.svh
// Assertion macros for the life automaton top level.
// Each macro checks on the rising edge of clk and is disabled while rst_n is low.
`ifndef LIFE_AUTOMATON_TORUS_TOP_MACROS_SVH
`define LIFE_AUTOMATON_TORUS_TOP_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication
`define LAT_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lat assertion failed");

// Next-cycle implication
`define LAT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lat assertion failed");

`else

`define LAT_ASSERT_IMPL(label, ante, cons)
`define LAT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: rtl/lat_pkg.sv
package lat_pkg;

  // Field widths of a command and of the size registers
  localparam int unsigned ACT_W  = 3;
  localparam int unsigned COL_W  = 6;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned SIZE_W = 7;

  // Command codes
  localparam logic [ACT_W-1:0] ACT_SET     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CLEAR   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_ADVANCE = 3'd2;
  localparam logic [ACT_W-1:0] ACT_WIPE    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_READ    = 3'd4;

  // Register indexes
  localparam logic REG_COLS = 1'b0;
  localparam logic REG_ROWS = 1'b1;

  // B3/S23 neighbour counts
  localparam logic [3:0] BIRTH_CNT = 4'd3;
  localparam logic [3:0] SURV_CNT  = 4'd2;

endpackage

// File: rtl/lat_grid_mem.sv
module lat_grid_mem #(
  parameter int unsigned WIDTH = 64,
  parameter int unsigned DEPTH = 64,
  parameter int unsigned AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  // One row of cells per entry
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/lat_row_unit.sv
module lat_row_unit #(
  parameter int unsigned WIDTH = 64
) (
  input  logic [WIDTH-1:0]             up_row,
  input  logic [WIDTH-1:0]             mid_row,
  input  logic [WIDTH-1:0]             dn_row,
  input  logic [lat_pkg::SIZE_W-1:0]   ncols,
  output logic [WIDTH-1:0]             nxt_row
);
  import lat_pkg::*;

  localparam int unsigned CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic [CW-1:0] last_col;
  logic          up_last;
  logic          mid_last;
  logic          dn_last;

  // Wrapped left neighbours of column 0 come from the last column in use
  assign last_col = CW'(ncols - SIZE_W'(1));
  assign up_last  = up_row[last_col];
  assign mid_last = mid_row[last_col];
  assign dn_last  = dn_row[last_col];

  // One neighbour count and rule per column, all columns of the row at once
  for (genvar c = 0; c < WIDTH; c++) begin : g_col
    logic       l_up, l_mid, l_dn;
    logic       r_up, r_mid, r_dn;
    logic       active;
    logic       is_last;
    logic       alive;
    logic [3:0] cnt;

    assign active  = (32'(ncols) > c);
    assign is_last = (32'(ncols) == (c + 1));

    if (c == 0) begin : g_left_wrap
      assign l_up  = up_last;
      assign l_mid = mid_last;
      assign l_dn  = dn_last;
    end else begin : g_left
      assign l_up  = up_row[c-1];
      assign l_mid = mid_row[c-1];
      assign l_dn  = dn_row[c-1];
    end

    if (c == WIDTH - 1) begin : g_right_wrap
      assign r_up  = up_row[0];
      assign r_mid = mid_row[0];
      assign r_dn  = dn_row[0];
    end else begin : g_right
      assign r_up  = is_last ? up_row[0]  : up_row[c+1];
      assign r_mid = is_last ? mid_row[0] : mid_row[c+1];
      assign r_dn  = is_last ? dn_row[0]  : dn_row[c+1];
    end

    assign cnt = 4'(l_up) + 4'(up_row[c]) + 4'(r_up) + 4'(l_mid) + 4'(r_mid)
               + 4'(l_dn) + 4'(dn_row[c]) + 4'(r_dn);

    assign alive = (cnt == BIRTH_CNT) || (mid_row[c] && (cnt == SURV_CNT));

    // Columns beyond the grid in use keep their contents
    assign nxt_row[c] = active ? alive : mid_row[c];
  end

endmodule

// File: rtl/life_automaton_torus_top.sv
// Channel  | Ports                           | Payload
// ---------+---------------------------------+------------------------------------
// command  | in_tvalid, in_tready, in_tdata  | action, col, row
// result   | out_tvalid, out_tready, out_tdata | cell_value, in_range
// config   | cfg_valid, cfg_ready, cfg_index, cfg_data | 0 cols_in_use, 1 rows_in_use
//
// Set, clear or read: registered row read of the grid memory, then patch or pick.
// Advance: PRE0, PRE1 and PRE2 fill the window, RUN does one grid row per cycle, DONE reports.
// Clear grid: one row of the memory zeroed per cycle, then the result is reported.
// After reset the grid memory is cleared row by row before a command is taken.
// A stalled result sits in the output register; the next command waits only at hand-over.
module life_automaton_torus_top #(
  parameter int unsigned MAX_COLS = 64,
  parameter int unsigned MAX_ROWS = 64
) (
  input  logic        clk,
  input  logic        rst_n,
  // command
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,    // [2:0] action, [8:3] col, [14:9] row, [15] zero
  // result
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,   // [0] cell_value, [1] in_range, [7:2] zero
  // configuration
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import lat_pkg::*;

  `include "life_automaton_torus_top_macros.svh"

  localparam int unsigned RAW = $clog2(MAX_ROWS);
  localparam int unsigned CW  = $clog2(MAX_COLS);
  localparam logic [SIZE_W-1:0] RST_COLS = SIZE_W'((MAX_COLS < 64) ? MAX_COLS : 64);
  localparam logic [SIZE_W-1:0] RST_ROWS = SIZE_W'((MAX_ROWS < 64) ? MAX_ROWS : 64);

  // Sequencer codes
  localparam logic [2:0] ST_CLR  = 3'd0;
  localparam logic [2:0] ST_IDLE = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_PRE0 = 3'd3;
  localparam logic [2:0] ST_PRE1 = 3'd4;
  localparam logic [2:0] ST_PRE2 = 3'd5;
  localparam logic [2:0] ST_RUN  = 3'd6;
  localparam logic [2:0] ST_DONE = 3'd7;

  logic [2:0]          state_r, state_nxt;
  logic [SIZE_W-1:0]   nc_r, nr_r;
  logic [ACT_W-1:0]    cmd_act_r, cmd_act_nxt;
  logic [COL_W-1:0]    cmd_col_r, cmd_col_nxt;
  logic [ROW_W-1:0]    cmd_row_r, cmd_row_nxt;
  logic                ok_r, ok_nxt;
  logic                res_r, res_nxt;
  logic                rsp_r, rsp_nxt;
  logic [RAW-1:0]      row_r, row_nxt;
  logic [MAX_COLS-1:0] up_r, up_nxt;
  logic [MAX_COLS-1:0] mid_r, mid_nxt;
  logic [MAX_COLS-1:0] first_r, first_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [1:0]          out_data_r, out_data_nxt;

  logic [ACT_W-1:0]    in_act;
  logic [COL_W-1:0]    in_col;
  logic [ROW_W-1:0]    in_row;
  logic                in_ok;
  logic                in_acc;
  logic [SIZE_W-1:0]   cfg_fit_cols, cfg_fit_rows;

  logic                mem_we;
  logic [RAW-1:0]      mem_waddr;
  logic [MAX_COLS-1:0] mem_wdata;
  logic [RAW-1:0]      mem_raddr;
  logic [MAX_COLS-1:0] mem_rdata;
  logic [MAX_COLS-1:0] dn_row;
  logic [MAX_COLS-1:0] nxt_row;
  logic                run_last;
  logic                slot_free;

  // Command fields
  assign in_act = in_tdata[2:0];
  assign in_col = in_tdata[8:3];
  assign in_row = in_tdata[14:9];
  assign in_ok  = ({1'b0, in_col} < nc_r) && ({1'b0, in_row} < nr_r);

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_data_r};
  assign slot_free  = !out_valid_r || out_tready;

  // Size registers hold the clamped value: zero reads as one, large values saturate
  assign cfg_fit_cols = (cfg_data == '0) ? SIZE_W'(1) :
                        (32'(cfg_data) > MAX_COLS) ? SIZE_W'(MAX_COLS) : cfg_data;
  assign cfg_fit_rows = (cfg_data == '0) ? SIZE_W'(1) :
                        (32'(cfg_data) > MAX_ROWS) ? SIZE_W'(MAX_ROWS) : cfg_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nc_r <= RST_COLS;
      nr_r <= RST_ROWS;
    end else if (cfg_valid && cfg_ready) begin
      if (cfg_index == REG_COLS) begin
        nc_r <= cfg_fit_cols;
      end else begin
        nr_r <= cfg_fit_rows;
      end
    end
  end

  // Generation window: the row below comes from memory, or the saved old row 0 at the wrap
  assign run_last = ((32'(row_r) + 1) == 32'(nr_r));
  assign dn_row   = run_last ? first_r : mem_rdata;

  lat_row_unit #(
    .WIDTH (MAX_COLS)
  ) u_row_unit (
    .up_row  (up_r),
    .mid_row (mid_r),
    .dn_row  (dn_row),
    .ncols   (nc_r),
    .nxt_row (nxt_row)
  );

  lat_grid_mem #(
    .WIDTH (MAX_COLS),
    .DEPTH (MAX_ROWS),
    .AW    (RAW)
  ) u_grid_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    cmd_act_nxt   = cmd_act_r;
    cmd_col_nxt   = cmd_col_r;
    cmd_row_nxt   = cmd_row_r;
    ok_nxt        = ok_r;
    res_nxt       = res_r;
    rsp_nxt       = rsp_r;
    row_nxt       = row_r;
    up_nxt        = up_r;
    mid_nxt       = mid_r;
    first_nxt     = first_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = row_r;
    mem_wdata     = '0;
    mem_raddr     = '0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLR: begin
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = '0;
        row_nxt   = row_r + RAW'(1);
        if (32'(row_r) == (MAX_ROWS - 1)) begin
          row_nxt   = '0;
          state_nxt = rsp_r ? ST_DONE : ST_IDLE;
        end
      end

      ST_IDLE: begin
        mem_raddr = RAW'(in_row);
        if (in_acc) begin
          cmd_act_nxt = in_act;
          cmd_col_nxt = in_col;
          cmd_row_nxt = in_row;
          ok_nxt      = in_ok;
          res_nxt     = in_ok && (in_act == ACT_SET);
          row_nxt     = '0;
          case (in_act)
            ACT_SET, ACT_CLEAR: begin
              mem_we    = 1'b1;
              mem_waddr = RAW'(in_row);
              mem_wdata = mem_rdata;
              state_nxt = ST_RD;
            end
            ACT_ADVANCE: begin
              state_nxt = ST_PRE0;
            end
            ACT_WIPE: begin
              rsp_nxt   = 1'b1;
              state_nxt = ST_CLR;
            end
            default: begin
              state_nxt = ST_RD;
            end
          endcase
          // set/clear: nothing written here, the row is patched after its read
          mem_we = 1'b0;
        end
      end

      ST_RD: begin
        // Row of the addressed cell is in the read register
        if ((cmd_act_r == ACT_SET) || (cmd_act_r == ACT_CLEAR)) begin
          mem_we    = ok_r;
          mem_waddr = RAW'(cmd_row_r);
          mem_wdata = mem_rdata;
          mem_wdata[CW'(cmd_col_r)] = (cmd_act_r == ACT_SET);
        end else begin
          res_nxt = ok_r && mem_rdata[CW'(cmd_col_r)];
        end
        state_nxt = ST_DONE;
      end

      ST_PRE0: begin
        mem_raddr = RAW'(nr_r - SIZE_W'(1));
        state_nxt = ST_PRE1;
      end

      ST_PRE1: begin
        mem_raddr = '0;
        up_nxt    = mem_rdata;
        state_nxt = ST_PRE2;
      end

      ST_PRE2: begin
        mem_raddr = (nr_r == SIZE_W'(1)) ? '0 : RAW'(1);
        mid_nxt   = mem_rdata;
        first_nxt = mem_rdata;
        state_nxt = ST_RUN;
      end

      ST_RUN: begin
        mem_we    = 1'b1;
        mem_waddr = row_r;
        mem_wdata = nxt_row;
        mem_raddr = ((32'(row_r) + 2) < 32'(nr_r)) ? (row_r + RAW'(2)) : '0;
        up_nxt    = mid_r;
        mid_nxt   = dn_row;
        if (32'(row_r) == 32'(cmd_row_r)) begin
          res_nxt = ok_r && nxt_row[CW'(cmd_col_r)];
        end
        if (run_last) begin
          row_nxt   = '0;
          state_nxt = ST_DONE;
        end else begin
          row_nxt = row_r + RAW'(1);
        end
      end

      ST_DONE: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = {ok_r, ok_r && res_r};
          rsp_nxt       = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      row_r       <= '0;
      rsp_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      row_r       <= row_nxt;
      rsp_r       <= rsp_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cmd_act_r  <= cmd_act_nxt;
    cmd_col_r  <= cmd_col_nxt;
    cmd_row_r  <= cmd_row_nxt;
    ok_r       <= ok_nxt;
    res_r      <= res_nxt;
    up_r       <= up_nxt;
    mid_r      <= mid_nxt;
    first_r    <= first_nxt;
    out_data_r <= out_data_nxt;
  end

  // Checks
  `LAT_ASSERT_IMPL(a_rise_from_done, $rose(out_valid_r), $past(state_r) == ST_DONE)
  `LAT_ASSERT_IMPL(a_out_of_range_dead, out_valid_r && !out_data_r[1], !out_data_r[0])
  `LAT_ASSERT_IMPL(a_run_row_in_grid, state_r == ST_RUN, 32'(row_r) < 32'(nr_r))
  `LAT_ASSERT_NEXT(a_accept_leaves_idle, in_acc, state_r != ST_IDLE)

endmodule
